### sv/best_fit_chunk_allocator_top_defines.svh
// Assertion macros for the best fit chunk allocator.
`ifndef BEST_FIT_CHUNK_ALLOCATOR_TOP_DEFINES_SVH
`define BEST_FIT_CHUNK_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BFCA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BFCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BFCA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BFCA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### sv/bfca_pkg.sv
// Types and constants of the best fit chunk allocator.
`timescale 1ns / 1ps
package bfca_pkg;
   localparam int DefaultMaxChunks = 64;
   localparam int DefaultHeaderBytes = 16;
   localparam logic [16:0] PoolMin = 17'd64;
   localparam logic [16:0] PoolMax = 17'd65536;
   localparam logic [16:0] PoolReset = 17'd65536;

   typedef enum logic { CMD_ALLOC = 1'b0, CMD_FREE = 1'b1 } cmd_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_NO_MEMORY = 2'd1, ST_BAD_OFFSET = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_SCAN, S_GROW, S_SPLIT1, S_SPLIT2, S_MARK,
      S_MERGE, S_SHRINK, S_STATS, S_DONE
   } state_type;

   typedef struct packed {
      logic [15:0] start;
      logic [16:0] size;
      logic        used;
      logic [16:0] hang;
   } chunk_type;
endpackage

### sv/bfca_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface bfca_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [16:0] request_bytes;
   logic [15:0] data_offset;
   modport source (output valid, cmd, request_bytes, data_offset, input ready);
   modport sink (input valid, cmd, request_bytes, data_offset, output ready);
endinterface

interface bfca_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] granted_offset;
   logic [16:0] granted_bytes;
   logic [16:0] overhang_bytes;
   logic [16:0] free_bytes_total;
   logic [16:0] largest_free;
   modport source (output valid, status, granted_offset, granted_bytes, overhang_bytes,
                   free_bytes_total, largest_free, input ready);
   modport sink (input valid, status, granted_offset, granted_bytes, overhang_bytes,
                 free_bytes_total, largest_free, output ready);
endinterface

### sv/best_fit_chunk_allocator_top.sv
// Best fit chunk allocator top level with its chunk table memory and sequencer.
`timescale 1ns / 1ps
`include "best_fit_chunk_allocator_top_defines.svh"
// The pool is kept as an address-ordered table of chunks in one single-port-read,
// single-port-write memory with a registered read. Each request is one transfer
// in and one transfer out. An allocate scans the table for the smallest free chunk
// that fits (lowest address on ties), then, if it splits, shifts the entries above
// it up by one and writes the two halves; a free scans for the matching used chunk,
// capturing its neighbors on the fly, writes the merged chunk and shifts the tail
// down. A last scan sums the free bytes and finds the largest free chunk. Each
// scan reads one table entry per cycle. A write to csr_wdata (pool size, clamped to
// 64..65536) resets the table to one free chunk. The response sits in an output
// register, so a new request is taken while the last result waits.
module best_fit_chunk_allocator_top #(
   parameter int MAX_CHUNKS = bfca_pkg::DefaultMaxChunks,
   parameter int HEADER_BYTES = bfca_pkg::DefaultHeaderBytes
) (
   input  logic        clock,
   input  logic        reset,
   bfca_req_if.sink    req,
   bfca_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic [16:0] csr_wdata
);
   localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int CW = $clog2(MAX_CHUNKS + 1);
   localparam logic [CW-1:0] MaxCount = CW'(MAX_CHUNKS);
   localparam logic [CW-1:0] One = CW'(1);
   localparam logic [16:0] Hdr = 17'(HEADER_BYTES);
   localparam logic [17:0] Hdr2 = 18'(2 * HEADER_BYTES);

   // chunk table
   bfca_pkg::chunk_type mem [MAX_CHUNKS];

   bfca_pkg::state_type state_ff, state_in;
   logic [16:0] pool_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] iss_ff, iss_in;
   logic rv_ff;
   logic [CW-1:0] ridx_ff;
   bfca_pkg::chunk_type rdata_ff;

   logic rd_en;
   logic [CW-1:0] rd_addr;
   logic wr_en;
   logic [CW-1:0] wr_addr;
   bfca_pkg::chunk_type wr_data;

   logic cmd_ff, cmd_in;
   logic [16:0] reqb_ff, reqb_in;
   logic [15:0] off_ff, off_in;
   logic found_ff, found_in;
   logic [CW-1:0] bidx_ff, bidx_in;
   bfca_pkg::chunk_type best_ff, best_in, prev_ff, prev_in, next_ff, next_in;
   logic [1:0] status_ff, status_in;
   logic [15:0] gofs_ff, gofs_in;
   logic [16:0] gbytes_ff, gbytes_in, ghang_ff, ghang_in;
   logic [16:0] total_ff, total_in, largest_ff, largest_in;

   logic rsp_vld_ff, rsp_vld_in;
   logic [1:0] o_status_ff;
   logic [15:0] o_gofs_ff;
   logic [16:0] o_gbytes_ff, o_ghang_ff, o_total_ff, o_largest_ff;
   logic load_rsp;

   logic [16:0] pool_sat;
   logic last_rd;
   logic split;
   logic has_prev, has_next;
   logic [1:0] kdel;
   logic [CW-1:0] pidx;
   logic [17:0] msize;
   logic [16:0] hit_ofs;

   always_comb begin
      pool_sat = pool_ff;
      if (pool_ff < bfca_pkg::PoolMin) pool_sat = bfca_pkg::PoolMin;
      if (pool_ff > bfca_pkg::PoolMax) pool_sat = bfca_pkg::PoolMax;
   end

   assign last_rd = rv_ff && (ridx_ff == count_ff - One);
   assign split = (count_ff < MaxCount)
                  && ({1'b0, best_ff.size} >= ({1'b0, reqb_ff} + Hdr2));

   // free: merged chunk lands at pidx, kdel entries drop out behind it
   assign has_next = ((bidx_ff + One) < count_ff) && !next_ff.used;
   assign has_prev = (bidx_ff != '0) && !prev_ff.used;
   assign kdel = {1'b0, has_next} + {1'b0, has_prev};
   assign pidx = has_prev ? bidx_ff - One : bidx_ff;
   assign msize = {1'b0, best_ff.size}
                  + (has_next ? {1'b0, next_ff.size} + {1'b0, Hdr} : 18'd0)
                  + (has_prev ? {1'b0, prev_ff.size} + {1'b0, Hdr} : 18'd0);
   assign hit_ofs = {1'b0, rdata_ff.start} + Hdr;

   assign req.ready = (state_ff == bfca_pkg::S_IDLE) && !csr_we;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      iss_in = iss_ff;
      rd_en = 1'b0;
      rd_addr = iss_ff;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = rdata_ff;
      cmd_in = cmd_ff;
      reqb_in = reqb_ff;
      off_in = off_ff;
      found_in = found_ff;
      bidx_in = bidx_ff;
      best_in = best_ff;
      prev_in = prev_ff;
      next_in = next_ff;
      status_in = status_ff;
      gofs_in = gofs_ff;
      gbytes_in = gbytes_ff;
      ghang_in = ghang_ff;
      total_in = total_ff;
      largest_in = largest_ff;
      load_rsp = 1'b0;
      unique case (state_ff)
         bfca_pkg::S_INIT: begin
            wr_en = 1'b1;
            wr_addr = '0;
            wr_data = '{start: 16'd0, size: pool_sat - Hdr, used: 1'b0, hang: 17'd0};
            count_in = One;
            state_in = bfca_pkg::S_IDLE;
         end
         bfca_pkg::S_IDLE: begin
            if (req.valid && req.ready) begin
               cmd_in = req.cmd;
               reqb_in = req.request_bytes;
               off_in = req.data_offset;
               found_in = 1'b0;
               bidx_in = '0;
               status_in = bfca_pkg::ST_OK;
               gofs_in = '0;
               gbytes_in = '0;
               ghang_in = '0;
               prev_in = '0;
               next_in = '0;
               iss_in = '0;
               state_in = bfca_pkg::S_SCAN;
            end
         end
         bfca_pkg::S_SCAN: begin
            rd_en = iss_ff < count_ff;
            if (rd_en) iss_in = iss_ff + One;
            if (rv_ff) begin
               if (cmd_ff == bfca_pkg::CMD_ALLOC) begin
                  if (!rdata_ff.used && rdata_ff.size >= reqb_ff
                      && (!found_ff || rdata_ff.size < best_ff.size)) begin
                     found_in = 1'b1;
                     bidx_in = ridx_ff;
                     best_in = rdata_ff;
                  end
               end else begin
                  if (found_ff && ridx_ff == bidx_ff + One) next_in = rdata_ff;
                  if (!found_ff) begin
                     if (rdata_ff.used && hit_ofs == {1'b0, off_ff}) begin
                        found_in = 1'b1;
                        bidx_in = ridx_ff;
                        best_in = rdata_ff;
                     end else begin
                        prev_in = rdata_ff;
                     end
                  end
               end
            end
            if (last_rd) begin
               total_in = '0;
               largest_in = '0;
               if (!found_in) begin
                  status_in = (cmd_ff == bfca_pkg::CMD_ALLOC) ? bfca_pkg::ST_NO_MEMORY
                                                             : bfca_pkg::ST_BAD_OFFSET;
                  iss_in = '0;
                  state_in = bfca_pkg::S_STATS;
               end else if (cmd_ff == bfca_pkg::CMD_FREE) begin
                  state_in = bfca_pkg::S_MERGE;
               end else begin
                  state_in = bfca_pkg::S_MARK;
               end
            end
         end
         bfca_pkg::S_MARK: begin
            // decide split now that the best chunk is settled
            gofs_in = best_ff.start + 16'(HEADER_BYTES);
            if (split) begin
               gbytes_in = reqb_ff;
               ghang_in = '0;
               iss_in = count_ff - One;
               state_in = (bidx_ff + One <= count_ff - One) ? bfca_pkg::S_GROW
                                                           : bfca_pkg::S_SPLIT1;
            end else begin
               gbytes_in = best_ff.size;
               ghang_in = best_ff.size - reqb_ff;
               wr_en = 1'b1;
               wr_addr = bidx_ff;
               wr_data = '{start: best_ff.start, size: best_ff.size, used: 1'b1,
                           hang: best_ff.size - reqb_ff};
               iss_in = '0;
               state_in = bfca_pkg::S_STATS;
            end
         end
         bfca_pkg::S_GROW: begin
            rd_en = iss_ff > bidx_ff;
            if (rd_en) iss_in = iss_ff - One;
            if (rv_ff) begin
               wr_en = 1'b1;
               wr_addr = ridx_ff + One;
               wr_data = rdata_ff;
               if (ridx_ff == bidx_ff + One) state_in = bfca_pkg::S_SPLIT1;
            end
         end
         bfca_pkg::S_SPLIT1: begin
            wr_en = 1'b1;
            wr_addr = bidx_ff;
            wr_data = '{start: best_ff.start, size: reqb_ff, used: 1'b1, hang: 17'd0};
            state_in = bfca_pkg::S_SPLIT2;
         end
         bfca_pkg::S_SPLIT2: begin
            wr_en = 1'b1;
            wr_addr = bidx_ff + One;
            wr_data = '{start: best_ff.start + 16'(HEADER_BYTES) + reqb_ff[15:0],
                        size: best_ff.size - reqb_ff - Hdr, used: 1'b0, hang: 17'd0};
            count_in = count_ff + One;
            iss_in = '0;
            state_in = bfca_pkg::S_STATS;
         end
         bfca_pkg::S_MERGE: begin
            wr_en = 1'b1;
            wr_addr = pidx;
            wr_data = '{start: has_prev ? prev_ff.start : best_ff.start, size: msize[16:0],
                        used: 1'b0, hang: 17'd0};
            iss_in = pidx + One + CW'(kdel);
            if (kdel != 2'd0 && (pidx + One + CW'(kdel)) < count_ff) begin
               state_in = bfca_pkg::S_SHRINK;
            end else begin
               count_in = count_ff - CW'(kdel);
               iss_in = '0;
               state_in = bfca_pkg::S_STATS;
            end
         end
         bfca_pkg::S_SHRINK: begin
            rd_en = iss_ff < count_ff;
            if (rd_en) iss_in = iss_ff + One;
            if (rv_ff) begin
               wr_en = 1'b1;
               wr_addr = ridx_ff - CW'(kdel);
               wr_data = rdata_ff;
               if (last_rd) begin
                  count_in = count_ff - CW'(kdel);
                  iss_in = '0;
                  state_in = bfca_pkg::S_STATS;
               end
            end
         end
         bfca_pkg::S_STATS: begin
            rd_en = iss_ff < count_ff;
            if (rd_en) iss_in = iss_ff + One;
            if (rv_ff && !rdata_ff.used) begin
               total_in = total_ff + rdata_ff.size;
               if (rdata_ff.size > largest_ff) largest_in = rdata_ff.size;
            end
            if (last_rd) state_in = bfca_pkg::S_DONE;
         end
         bfca_pkg::S_DONE: begin
            if (!rsp_vld_ff || rsp.ready) begin
               load_rsp = 1'b1;
               state_in = bfca_pkg::S_IDLE;
            end
         end
         default: state_in = bfca_pkg::S_INIT;
      endcase
      if (csr_we) state_in = bfca_pkg::S_INIT;
   end

   assign rsp_vld_in = load_rsp ? 1'b1 : (rsp.ready ? 1'b0 : rsp_vld_ff);

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr[AW-1:0]] <= wr_data;
      if (rd_en) rdata_ff <= mem[rd_addr[AW-1:0]];
      ridx_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfca_pkg::S_INIT;
         pool_ff <= bfca_pkg::PoolReset;
         count_ff <= One;
         rv_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) pool_ff <= csr_wdata;
         count_ff <= count_in;
         rv_ff <= rd_en;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff <= iss_in;
      cmd_ff <= cmd_in;
      reqb_ff <= reqb_in;
      off_ff <= off_in;
      found_ff <= found_in;
      bidx_ff <= bidx_in;
      best_ff <= best_in;
      prev_ff <= prev_in;
      next_ff <= next_in;
      status_ff <= status_in;
      gofs_ff <= gofs_in;
      gbytes_ff <= gbytes_in;
      ghang_ff <= ghang_in;
      total_ff <= total_in;
      largest_ff <= largest_in;
      if (load_rsp) begin
         o_status_ff <= status_ff;
         o_gofs_ff <= gofs_ff;
         o_gbytes_ff <= gbytes_ff;
         o_ghang_ff <= ghang_ff;
         o_total_ff <= total_ff;
         o_largest_ff <= largest_ff;
      end
   end

   assign rsp.valid = rsp_vld_ff;
   assign rsp.status = o_status_ff;
   assign rsp.granted_offset = o_gofs_ff;
   assign rsp.granted_bytes = o_gbytes_ff;
   assign rsp.overhang_bytes = o_ghang_ff;
   assign rsp.free_bytes_total = o_total_ff;
   assign rsp.largest_free = o_largest_ff;

   `BFCA_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff >= One && count_ff <= MaxCount)
   `BFCA_ASSERT_IMPL(a_grow_room, clock, reset, state_ff == bfca_pkg::S_GROW, count_ff < MaxCount)
   `BFCA_ASSERT_NEXT(a_take_starts, clock, reset, req.valid && req.ready && !csr_we,
                     state_ff == bfca_pkg::S_SCAN || state_ff == bfca_pkg::S_INIT)
   `BFCA_ASSERT_IMPL(a_fail_zero, clock, reset, rsp_vld_ff && o_status_ff != bfca_pkg::ST_OK,
                     o_gofs_ff == 16'd0 && o_gbytes_ff == 17'd0 && o_ghang_ff == 17'd0)
endmodule

### test/tb_best_fit_chunk_allocator_top.sv
// Self-checking testbench for the best fit chunk allocator top level.
`timescale 1ns / 1ps
module tb_best_fit_chunk_allocator_top;

   localparam int NCH = 64;
   localparam int HDR = 16;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic        cmd;
      logic [16:0] nbytes;
      logic [15:0] offset;
   } alloc_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] gofs;
      logic [16:0] gbytes;
      logic [16:0] ghang;
      logic [16:0] total;
      logic [16:0] largest;
   } alloc_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [16:0] csr_wdata = '0;

   bfca_req_if req ();
   bfca_rsp_if rsp ();

   best_fit_chunk_allocator_top dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // Shadow copy of the chunk table
   int unsigned tbl_start [NCH];
   int unsigned tbl_size [NCH];
   bit          tbl_used [NCH];
   int unsigned tbl_hang [NCH];
   int unsigned tbl_count;

   alloc_req_type pending_reqs[$];
   alloc_rsp_type expected_rsps[$];
   int unsigned live_offsets[$];   // data offsets of granted chunks
   int errors = 0;
   int cycles = 0;
   bit quiet = 1'b0;               // no idling near the end

   task automatic table_reset(input logic [16:0] pool);
      int unsigned p;
      p = pool;
      if (p < 64) p = 64;
      if (p > 65536) p = 65536;
      for (int i = 0; i < NCH; i++) begin
         tbl_start[i] = 0; tbl_size[i] = 0; tbl_used[i] = 0; tbl_hang[i] = 0;
      end
      tbl_size[0] = p - HDR;
      tbl_count = 1;
      live_offsets.delete();
   endtask

   function automatic void entry_move(input int unsigned dst, input int unsigned src);
      tbl_start[dst] = tbl_start[src];
      tbl_size[dst] = tbl_size[src];
      tbl_used[dst] = tbl_used[src];
      tbl_hang[dst] = tbl_hang[src];
   endfunction

   function automatic void entry_drop(input int unsigned k);
      for (int unsigned i = k; i + 1 < tbl_count; i++) entry_move(i, i + 1);
      tbl_count--;
   endfunction

   // Apply one request to the shadow table and return the expected response
   function automatic alloc_rsp_type predict_alloc(input alloc_req_type r);
      alloc_rsp_type o;
      int unsigned best, hit, sz, req_b;
      bit found;
      o = '0;
      req_b = r.nbytes;
      found = 0; best = 0;
      if (r.cmd == bfca_pkg::CMD_ALLOC) begin
         for (int unsigned i = 0; i < tbl_count; i++)
            if (!tbl_used[i] && tbl_size[i] >= req_b &&
                (!found || tbl_size[i] < tbl_size[best])) begin
               best = i; found = 1;
            end
         if (!found) o.status = bfca_pkg::ST_NO_MEMORY;
         else begin
            sz = tbl_size[best];
            if (tbl_count < NCH && sz >= req_b + 2 * HDR) begin
               for (int unsigned i = tbl_count; i > best + 1; i--) entry_move(i, i - 1);
               tbl_start[best + 1] = tbl_start[best] + HDR + req_b;
               tbl_size[best + 1] = sz - req_b - HDR;
               tbl_used[best + 1] = 0;
               tbl_hang[best + 1] = 0;
               tbl_count++;
               tbl_size[best] = req_b;
               tbl_hang[best] = 0;
            end else tbl_hang[best] = sz - req_b;
            tbl_used[best] = 1;
            o.status = bfca_pkg::ST_OK;
            o.gofs = 16'(tbl_start[best] + HDR);
            o.gbytes = 17'(tbl_size[best]);
            o.ghang = 17'(tbl_hang[best]);
         end
      end else begin
         hit = 0;
         for (int unsigned i = 0; i < tbl_count; i++)
            if (tbl_used[i] && tbl_start[i] + HDR == r.offset) begin
               hit = i; found = 1; break;
            end
         if (!found) o.status = bfca_pkg::ST_BAD_OFFSET;
         else begin
            tbl_used[hit] = 0;
            tbl_hang[hit] = 0;
            if (hit + 1 < tbl_count && !tbl_used[hit + 1]) begin
               tbl_size[hit] += tbl_size[hit + 1] + HDR;
               entry_drop(hit + 1);
            end
            if (hit > 0 && !tbl_used[hit - 1]) begin
               tbl_size[hit - 1] += tbl_size[hit] + HDR;
               entry_drop(hit);
            end
         end
      end
      for (int unsigned i = 0; i < tbl_count; i++)
         if (!tbl_used[i]) begin
            o.total += 17'(tbl_size[i]);
            if (tbl_size[i] > o.largest) o.largest = 17'(tbl_size[i]);
         end
      return o;
   endfunction

   // Queue a request; track live offsets so frees mostly hit granted chunks
   task automatic push_req(input logic cmd, input logic [16:0] nb, input logic [15:0] ofs);
      alloc_req_type r;
      alloc_rsp_type o;
      r.cmd = cmd; r.nbytes = nb; r.offset = ofs;
      o = predict_alloc(r);
      if (cmd == bfca_pkg::CMD_ALLOC && o.status == bfca_pkg::ST_OK)
         live_offsets.push_back(o.gofs);
      if (cmd == bfca_pkg::CMD_FREE && o.status == bfca_pkg::ST_OK)
         foreach (live_offsets[i]) if (live_offsets[i] == ofs) begin
            live_offsets.delete(i); break;
         end
      pending_reqs.push_back(r);
      expected_rsps.push_back(o);
   endtask

   task automatic push_free_live();
      int k;
      logic [15:0] ofs;
      if (live_offsets.size() == 0)
         push_req(bfca_pkg::CMD_FREE, 17'($urandom), 16'($urandom));
      else begin
         k = $urandom_range(live_offsets.size() - 1);
         ofs = 16'(live_offsets[k]);
         push_req(bfca_pkg::CMD_FREE, 17'($urandom), ofs);
      end
   endtask

   // Drain, settle, then write the pool register at a falling edge
   task automatic set_pool(input logic [16:0] v);
      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
      repeat (300) @(posedge clock);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      table_reset(v);
   endtask

   // Random phase: mostly alloc/free mixes on the current pool, allocs up to max_req
   task automatic random_phase(input int n, input int unsigned max_req);
      int unsigned sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 50)
            push_req(bfca_pkg::CMD_ALLOC, 17'($urandom_range(max_req)), 16'($urandom));
         else if (sel < 90) push_free_live();
         else if (sel < 95) push_req(bfca_pkg::CMD_FREE, 17'($urandom), 16'($urandom));
         else push_req(bfca_pkg::CMD_ALLOC, 17'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      forever #6 clock = ~clock;
   end

   // Request driver: changes at the falling edge, idles in short bursts
   int req_gap = 0;
   int unsigned req_taken = 0;     // transfers seen at rising edges
   int unsigned req_held = 0;      // transfers already retired by the driver
   initial begin
      req.valid = 1'b0; req.cmd = 1'b0; req.request_bytes = '0; req.data_offset = '0;
   end
   always @(negedge clock) begin
      if (!reset) begin
         if (!req.valid || req_taken != req_held) begin
            req_held <= req_taken;
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req.valid <= 1'b1;
               req.cmd <= pending_reqs[0].cmd;
               req.request_bytes <= pending_reqs[0].nbytes;
               req.data_offset <= pending_reqs[0].offset;
               if (!quiet && $urandom_range(3) == 0) req_gap <= $urandom_range(1, 3);
            end else req.valid <= 1'b0;
         end
      end
   end
   // Transfer accepted: retire the head of the pending queue
   always @(posedge clock)
      if (!reset && req.valid && req.ready) begin
         void'(pending_reqs.pop_front());
         req_taken <= req_taken + 1;
      end

   // Response sink: ready toggles in bursts
   int rsp_gap = 0;
   initial rsp.ready = 1'b0;
   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
         if (!quiet && $urandom_range(3) == 0) rsp_gap <= $urandom_range(1, 3);
      end
   end

   // Monitor: compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      alloc_rsp_type exp_r, got;
      if (!reset && rsp.valid && rsp.ready) begin
         got = {rsp.status, rsp.granted_offset, rsp.granted_bytes, rsp.overhang_bytes,
                rsp.free_bytes_total, rsp.largest_free};
         if (expected_rsps.size() == 0) begin
            $display("%0t unexpected response %h", $realtime, got);
            errors++;
         end else begin
            exp_r = expected_rsps.pop_front();
            if (got.status !== exp_r.status) begin
               $display("%0t status exp %0d got %0d", $realtime, exp_r.status, got.status);
               errors++;
            end
            if (got.gofs !== exp_r.gofs) begin
               $display("%0t offset exp %0d got %0d", $realtime, exp_r.gofs, got.gofs);
               errors++;
            end
            if (got.gbytes !== exp_r.gbytes) begin
               $display("%0t granted exp %0d got %0d", $realtime, exp_r.gbytes, got.gbytes);
               errors++;
            end
            if (got.ghang !== exp_r.ghang) begin
               $display("%0t overhang exp %0d got %0d", $realtime, exp_r.ghang, got.ghang);
               errors++;
            end
            if (got.total !== exp_r.total) begin
               $display("%0t free total exp %0d got %0d", $realtime, exp_r.total, got.total);
               errors++;
            end
            if (got.largest !== exp_r.largest) begin
               $display("%0t largest exp %0d got %0d", $realtime, exp_r.largest,
                        got.largest);
               errors++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Stimulus sequence
   initial begin
      table_reset(bfca_pkg::PoolReset);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset pool, zero requests, full pool, oversize, bad and good frees
      push_req(bfca_pkg::CMD_ALLOC, 17'd0, 16'd0);
      push_req(bfca_pkg::CMD_ALLOC, 17'd100, 16'hFFFF);
      push_req(bfca_pkg::CMD_ALLOC, 17'h1FFFF, 16'd0);
      push_req(bfca_pkg::CMD_ALLOC, 17'd65536, 16'd0);
      push_req(bfca_pkg::CMD_FREE, 17'd0, 16'd0);
      push_req(bfca_pkg::CMD_FREE, 17'h1FFFF, 16'hFFFF);
      push_req(bfca_pkg::CMD_FREE, 17'd0, 16'd16);       // free first chunk, right neighbor still used
      push_req(bfca_pkg::CMD_FREE, 17'd0, 16'd48);       // bad offset, no chunk there
      push_req(bfca_pkg::CMD_FREE, 17'd0, 16'd48);       // same bad offset again
      push_req(bfca_pkg::CMD_ALLOC, 17'd65520, 16'd0);   // whole-pool size, no memory
      push_req(bfca_pkg::CMD_ALLOC, 17'd0, 16'd0);       // zero request reuses the freed first chunk
      push_req(bfca_pkg::CMD_FREE, 17'd0, 16'd16);

      // Smallest pool: below-range write saturates, overhang without split
      set_pool(17'd0);
      push_req(bfca_pkg::CMD_ALLOC, 17'd20, 16'd0);
      push_req(bfca_pkg::CMD_ALLOC, 17'd0, 16'd0);
      push_req(bfca_pkg::CMD_FREE, 17'd0, 16'd16);
      push_req(bfca_pkg::CMD_ALLOC, 17'd48, 16'd0);
      push_req(bfca_pkg::CMD_ALLOC, 17'd1, 16'd0);

      // Table full: many small grants fill every entry
      set_pool(17'd4096);
      for (int i = 0; i < 66; i++)
         push_req(bfca_pkg::CMD_ALLOC, 17'($urandom_range(8)), 16'd0);
      random_phase(150, 64);

      // Random phases over several pool sizes, small requests mostly
      set_pool(17'd64);
      random_phase(80, 60);
      set_pool(17'd1000);
      random_phase(250, 120);
      set_pool(17'h1FFFF);
      random_phase(250, 2000);
      set_pool(17'd65536);
      random_phase(250, 65536);
      set_pool(17'($urandom_range(64, 65536)));
      quiet = 1'b1;
      random_phase(250, 800);

      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
